[rtl/exponential_adsr_envelope_core_macros.svh]
// Assertion macros shared by the envelope core modules.
// Included by the controller and the datapath; no other dependencies.
`ifndef EXPONENTIAL_ADSR_ENVELOPE_CORE_MACROS_SVH
`define EXPONENTIAL_ADSR_ENVELOPE_CORE_MACROS_SVH
`ifndef SYNTH
`define EXPADSR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define EXPADSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EXPADSR_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define EXPADSR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[rtl/expadsr_pkg.sv]
// Types, constants and the log table of the exponential envelope core.
// No dependencies.
`timescale 1ns / 1ps
package expadsr_pkg;

    localparam int LEVEL_W = 25;
    localparam int COUNT_W = 24;
    localparam int LN_W    = 21;
    localparam int MULT_W  = 32;
    localparam int DIVD_W  = 35;
    localparam int PROD_W  = 57;
    localparam int IDX_W   = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 25'h1000000;
    localparam logic [MULT_W-1:0]  MULT_ONE  = 32'h40000000;
    localparam logic [15:0]        LN2_Q16   = 16'd45426;

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [IDX_W-1:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_RELEASE = 3'd2,
        REG_SUSTAIN = 3'd3,
        REG_FLOOR   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic capture;
        logic enter;
        logic ln_load;
        logic ln_norm;
        logic ln_mult;
        logic ln_sum;
        logic ln_sel;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic mul;
        logic round;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic ns_ok;
        logic timed;
        logic at_end;
        logic need_calc;
        logic norm_done;
        logic div_done;
        logic out_free;
    } t_sts;

    // ln(1 + i/16) in Q0.16.
    function automatic logic [15:0] ln_tab(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41196;
            5'd15:   v = 16'd43345;
            5'd16:   v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/expadsr_if.sv]
// Handshake channels of the envelope core: input word, result word, register write.
// Depends on nothing.
`timescale 1ns / 1ps
interface expadsr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [2:0] new_stage;
    modport source (output valid, output func, output new_stage, input ready);
    modport sink (input valid, input func, input new_stage, output ready);
endinterface

interface expadsr_out_if;
    logic        valid;
    logic        ready;
    logic [24:0] level;
    logic [2:0]  stage;
    modport source (output valid, output level, output stage, input ready);
    modport sink (input valid, input level, input stage, output ready);
endinterface

interface expadsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [24:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/expadsr_ctrl.sv]
// Sequencer of the envelope core: steps the datapath through stage entry,
// log evaluation, division and level update. Depends on expadsr_pkg and the macros.
`timescale 1ns / 1ps
`include "exponential_adsr_envelope_core_macros.svh"
module expadsr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  expadsr_pkg::t_sts   i_sts,
    output expadsr_pkg::t_cmd   o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DECODE   = 13'b0000000000010,
        S_ENTER    = 13'b0000000000100,
        S_PREP     = 13'b0000000001000,
        S_LN_LOAD  = 13'b0000000010000,
        S_LN_NORM  = 13'b0000000100000,
        S_LN_MULT  = 13'b0000001000000,
        S_LN_SUM   = 13'b0000010000000,
        S_DIV_INIT = 13'b0000100000000,
        S_DIV_STEP = 13'b0001000000000,
        S_DIV_FIN  = 13'b0010000000000,
        S_MUL      = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_tick, n_tick;
    logic   r_round, n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_tick   <= 1'b0;
            r_round  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_tick   <= n_tick;
            r_round  <= n_round;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_tick   = r_tick;
        n_round  = r_round;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.func) begin
                    n_tick  = 1'b0;
                    n_state = i_sts.ns_ok ? S_ENTER : S_DONE;
                end else if (i_sts.timed) begin
                    n_tick  = 1'b1;
                    n_state = i_sts.at_end ? S_ENTER : S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ENTER: begin
                o_cmd.enter = 1'b1;
                n_state     = S_PREP;
            end
            S_PREP: begin
                if (i_sts.need_calc) begin
                    n_second = 1'b0;
                    n_state  = S_LN_LOAD;
                end else begin
                    n_state = r_tick ? S_MUL : S_DONE;
                end
            end
            S_LN_LOAD: begin
                o_cmd.ln_load = 1'b1;
                o_cmd.ln_sel  = r_second;
                n_state       = S_LN_NORM;
            end
            S_LN_NORM: begin
                if (i_sts.norm_done) begin
                    n_state = S_LN_MULT;
                end else begin
                    o_cmd.ln_norm = 1'b1;
                end
            end
            S_LN_MULT: begin
                o_cmd.ln_mult = 1'b1;
                n_state       = S_LN_SUM;
            end
            S_LN_SUM: begin
                o_cmd.ln_sum = 1'b1;
                o_cmd.ln_sel = r_second;
                if (r_second) begin
                    n_state = S_DIV_INIT;
                end else begin
                    n_second = 1'b1;
                    n_state  = S_LN_LOAD;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (i_sts.div_done) begin
                    n_state = S_DIV_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIV_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = r_tick ? S_MUL : S_DONE;
            end
            S_MUL: begin
                // First pass forms the product, second pass rounds it.
                if (r_round) begin
                    o_cmd.round = 1'b1;
                    n_round     = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_round   = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    `EXPADSR_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DECODE)
    `EXPADSR_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `EXPADSR_ASSERT_NEXT(a_div_exit, i_clk, i_rst_n, r_state == S_DIV_STEP && i_sts.div_done, r_state == S_DIV_FIN)

endmodule

[rtl/expadsr_dp.sv]
// Datapath of the envelope core: registers, envelope state, log unit,
// serial divider, level multiplier and result register. Depends on expadsr_pkg and the macros.
`timescale 1ns / 1ps
`include "exponential_adsr_envelope_core_macros.svh"
module expadsr_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  expadsr_pkg::t_cmd                      i_cmd,
    output expadsr_pkg::t_sts                      o_sts,
    input  logic                                   i_func,
    input  logic [2:0]                             i_new_stage,
    input  logic                                   i_cfg_valid,
    input  logic [expadsr_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [expadsr_pkg::LEVEL_W-1:0]        i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [expadsr_pkg::LEVEL_W-1:0]        o_level,
    output logic [2:0]                             o_stage
);

    localparam int LW = expadsr_pkg::LEVEL_W;
    localparam int CW = expadsr_pkg::COUNT_W;
    localparam int NW = expadsr_pkg::LN_W;
    localparam int MW = expadsr_pkg::MULT_W;
    localparam int DW = expadsr_pkg::DIVD_W;
    localparam int PW = expadsr_pkg::PROD_W;
    localparam logic [31:0] MULT_ONE_HALF = 32'h20000000;

    // Configuration and envelope state.
    logic [CW-1:0]        r_atk, r_dec, r_rel;
    logic [LW-1:0]        r_sus, r_flr;
    logic [LW-1:0]        r_level;
    logic [MW-1:0]        r_mult;
    expadsr_pkg::t_stage  r_stage;
    logic [CW-1:0]        r_count, r_len;
    logic                 r_ovalid;
    logic [LW-1:0]        r_olevel;
    logic [2:0]           r_ostage;

    // Working registers.
    logic                 r_func;
    logic [2:0]           r_ns;
    logic [LW-1:0]        r_opa, r_opb;
    logic [LW-1:0]        r_lx;
    logic [4:0]           r_lp;
    logic [15:0]          r_lo, r_frac;
    logic [NW-1:0]        r_pl, r_lna, r_lnb;
    logic                 r_neg;
    logic [DW-1:0]        r_quo;
    logic [CW-1:0]        r_rem;
    logic [5:0]           r_dcnt;
    logic [PW-1:0]        r_prod;

    logic [LW-1:0]        sus, flr0, flr, end_d;
    expadsr_pkg::t_stage  tgt;
    logic [CW-1:0]        n_len;
    logic [LW-1:0]        n_level, n_opa, n_opb;
    logic [4:0]           tab_i;
    logic [15:0]          tab_lo, tab_hi;
    logic [31:0]          interp;
    logic [NW-1:0]        ln_sum, ln_mag;
    logic [CW:0]          trial;
    logic                 trial_ge;
    logic [DW:0]          mult_up;
    logic [MW-1:0]        n_mult;
    logic [PW-1:0]        prod_rnd;
    logic [PW-31:0]       prod_q;
    logic [LW-1:0]        n_round;

    assign sus   = (r_sus > expadsr_pkg::LEVEL_ONE) ? expadsr_pkg::LEVEL_ONE : r_sus;
    assign flr0  = (r_flr == '0) ? LW'(1) : r_flr;
    assign flr   = (flr0 > expadsr_pkg::LEVEL_ONE) ? expadsr_pkg::LEVEL_ONE : flr0;
    assign end_d = (sus > flr) ? sus : flr;

    // Stage to enter: the commanded one, or the successor at the end of a timed stage.
    always_comb begin
        if (r_func) begin
            tgt = expadsr_pkg::t_stage'(r_ns);
        end else begin
            case (r_stage)
                expadsr_pkg::ST_ATTACK: tgt = expadsr_pkg::ST_DECAY;
                expadsr_pkg::ST_DECAY:  tgt = expadsr_pkg::ST_SUSTAIN;
                default:                tgt = expadsr_pkg::ST_OFF;
            endcase
        end
    end

    always_comb begin
        n_len   = '0;
        n_level = '0;
        n_opa   = '0;
        n_opb   = '0;
        case (tgt)
            expadsr_pkg::ST_ATTACK: begin
                n_len   = r_atk;
                n_level = flr;
                n_opa   = flr;
                n_opb   = expadsr_pkg::LEVEL_ONE;
            end
            expadsr_pkg::ST_DECAY: begin
                n_len   = r_dec;
                n_level = expadsr_pkg::LEVEL_ONE;
                n_opa   = expadsr_pkg::LEVEL_ONE;
                n_opb   = end_d;
            end
            expadsr_pkg::ST_SUSTAIN: begin
                n_level = sus;
            end
            expadsr_pkg::ST_RELEASE: begin
                n_len   = r_rel;
                n_level = r_level;
                n_opa   = r_level;
                n_opb   = flr;
            end
            default: begin
                n_level = '0;
            end
        endcase
    end

    // Log: the normalized word has its leading one at the top; the next four
    // bits pick the table segment and the sixteen after weight the interpolation.
    assign tab_i  = {1'b0, r_lx[LW-2:LW-5]};
    assign tab_lo = expadsr_pkg::ln_tab(tab_i);
    assign tab_hi = expadsr_pkg::ln_tab(tab_i + 5'd1);
    assign interp = (tab_hi - tab_lo) * r_lx[LW-6:LW-21];
    assign ln_sum = r_pl + NW'(r_lo) + NW'(r_frac);
    assign ln_mag = (r_lna > r_lnb) ? (r_lna - r_lnb) : (r_lnb - r_lna);

    assign trial    = {r_rem, r_quo[DW-1]};
    assign trial_ge = (trial >= {1'b0, r_len});

    assign mult_up = {1'b0, r_quo} + (DW+1)'(expadsr_pkg::MULT_ONE);
    always_comb begin
        if (r_neg) begin
            n_mult = (r_quo >= DW'(expadsr_pkg::MULT_ONE)) ? '0
                   : (expadsr_pkg::MULT_ONE - r_quo[MW-1:0]);
        end else begin
            n_mult = (mult_up[DW:MW] != '0) ? {MW{1'b1}} : mult_up[MW-1:0];
        end
    end

    assign prod_rnd = r_prod + PW'(MULT_ONE_HALF);
    assign prod_q   = prod_rnd[PW-1:30];
    assign n_round  = (prod_q > (PW-30)'(expadsr_pkg::LEVEL_ONE)) ? expadsr_pkg::LEVEL_ONE
                    : prod_q[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atk    <= CW'(441);
            r_dec    <= CW'(22050);
            r_rel    <= CW'(44100);
            r_sus    <= LW'(11744051);
            r_flr    <= LW'(1678);
            r_level  <= '0;
            r_mult   <= expadsr_pkg::MULT_ONE;
            r_stage  <= expadsr_pkg::ST_OFF;
            r_count  <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (expadsr_pkg::t_reg_idx'(i_cfg_index))
                    expadsr_pkg::REG_ATTACK:  r_atk <= i_cfg_data[CW-1:0];
                    expadsr_pkg::REG_DECAY:   r_dec <= i_cfg_data[CW-1:0];
                    expadsr_pkg::REG_RELEASE: r_rel <= i_cfg_data[CW-1:0];
                    expadsr_pkg::REG_SUSTAIN: r_sus <= i_cfg_data;
                    expadsr_pkg::REG_FLOOR:   r_flr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.enter) begin
                r_stage <= tgt;
                r_count <= '0;
                r_len   <= n_len;
                r_level <= n_level;
                r_mult  <= expadsr_pkg::MULT_ONE;
            end
            if (i_cmd.div_fin) begin
                r_mult <= n_mult;
            end
            if (i_cmd.round) begin
                r_level <= n_round;
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_ns   <= i_new_stage;
        end
        if (i_cmd.enter) begin
            r_opa <= n_opa;
            r_opb <= n_opb;
        end
        if (i_cmd.ln_load) begin
            r_lx <= i_cmd.ln_sel ? r_opb : r_opa;
            r_lp <= 5'(LW-1);
        end else if (i_cmd.ln_norm) begin
            if (r_lx[LW-1:LW-4] == '0) begin
                r_lx <= r_lx << 4;
                r_lp <= r_lp - 5'd4;
            end else begin
                r_lx <= r_lx << 1;
                r_lp <= r_lp - 5'd1;
            end
        end
        if (i_cmd.ln_mult) begin
            r_lo   <= tab_lo;
            r_frac <= interp[31:16];
            r_pl   <= NW'(r_lp) * NW'(expadsr_pkg::LN2_Q16);
        end
        if (i_cmd.ln_sum) begin
            if (i_cmd.ln_sel) begin
                r_lnb <= ln_sum;
            end else begin
                r_lna <= ln_sum;
            end
        end
        if (i_cmd.div_init) begin
            r_neg  <= (r_lna > r_lnb);
            r_quo  <= {ln_mag, 14'd0};
            r_rem  <= '0;
            r_dcnt <= 6'(DW);
        end else if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? CW'(trial - {1'b0, r_len}) : trial[CW-1:0];
            r_quo  <= {r_quo[DW-2:0], trial_ge};
            r_dcnt <= r_dcnt - 6'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_level) * PW'(r_mult);
        end
        if (i_cmd.out_load) begin
            r_olevel <= r_level;
            r_ostage <= r_stage;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.func      = r_func;
        o_sts.ns_ok     = (r_ns <= expadsr_pkg::ST_RELEASE);
        o_sts.timed     = (r_stage == expadsr_pkg::ST_ATTACK)
                       || (r_stage == expadsr_pkg::ST_DECAY)
                       || (r_stage == expadsr_pkg::ST_RELEASE);
        o_sts.at_end    = (r_count == r_len);
        o_sts.need_calc = o_sts.timed && (r_len != '0) && (r_opa != '0) && (r_opb != '0);
        o_sts.norm_done = r_lx[LW-1];
        o_sts.div_done  = (r_dcnt == '0);
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_level     = r_olevel;
    assign o_stage     = r_ostage;

    `EXPADSR_ASSERT_IMPL(a_level_sat, i_clk, i_rst_n, 1'b1, r_level <= expadsr_pkg::LEVEL_ONE)
    `EXPADSR_ASSERT_IMPL(a_norm_nonzero, i_clk, i_rst_n, i_cmd.ln_norm, r_lx != '0)
    `EXPADSR_ASSERT_NEXT(a_enter_clears, i_clk, i_rst_n, i_cmd.enter, r_count == '0)

endmodule

[rtl/exponential_adsr_envelope_core.sv]
// Top level of the exponential ADSR envelope core.
// Depends on expadsr_pkg, the channel interfaces, expadsr_ctrl and expadsr_dp.
`timescale 1ns / 1ps
// Each accepted word is a sample tick or a stage command and yields one result word
// holding the level (unsigned Q1.24) and the stage. A tick inside attack, decay or
// release multiplies and rounds the level, then waits for the output to be free; a
// tick or command that only holds the state skips the arithmetic. Entering a timed
// stage with a nonzero length and level evaluates two logs in a shared normalize and
// table unit and then divides in a one-bit-per-cycle restoring divider; a tick that
// also ends the stage then multiplies and rounds the level as well.
// Register writes are taken at any time and apply to the next stage entry.
module exponential_adsr_envelope_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    expadsr_in_if.sink     i_in,
    expadsr_out_if.source  o_out,
    expadsr_cfg_if.sink    i_cfg
);

    expadsr_pkg::t_cmd cmd;
    expadsr_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    expadsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    expadsr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_in.func),
        .i_new_stage (i_in.new_stage),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_level     (o_out.level),
        .o_stage     (o_out.stage)
    );

endmodule
